>>> rtl/core/ppfa_pkg.sv
// ----------------------------------------------------------------------------
// ppfa_pkg
// Shared types and constants of the page frame allocator: command codes,
// result status codes, the internal operation word passed from the front
// end to the back end, and the bitmap row geometry.
// ----------------------------------------------------------------------------
package ppfa_pkg;

    // Input command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SEARCH_START = 1'b0;
    localparam logic CFG_PAGE_LIMIT   = 1'b1;

    // Configuration reset values
    localparam logic [11:0] RESET_SEARCH_START = 12'h030;
    localparam logic [12:0] RESET_PAGE_LIMIT   = 13'd4096;

    // Field widths
    localparam int CFG_DATA_W = 13;
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 7;

    // Bitmap rows: one memory word holds the in-use bits of WORD_W pages
    localparam int WORD_W   = 64;
    localparam int WORD_IDX = 6;

    // Page bounds carry up to the largest page count plus one
    localparam int BOUND_W = 17;

    // Operation classes decided by the front end
    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_MARK  = 2'd2
    } t_op;

    // Operation word queued between front and back
    typedef struct packed {
        t_op                op;
        logic               mark_set;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic [COUNT_W-1:0] count;
        logic [1:0]         status;
    } t_cmd;

endpackage

>>> rtl/core/ppfa_front.sv
// ----------------------------------------------------------------------------
// ppfa_front
// Holds the configuration registers and classifies each accepted command
// word into an operation for the back end: page bounds, clipping status,
// saturated burst count, or an immediate single result.
// ----------------------------------------------------------------------------
module ppfa_front #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [ppfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]                       i_command,
    input  logic [11:0]                      i_page_index,
    input  logic [ppfa_pkg::COUNT_W-1:0]     i_page_count,
    output ppfa_pkg::t_cmd                   o_cmd
);

    logic [11:0]                      r_search_start;
    logic [12:0]                      r_page_limit;
    logic [ppfa_pkg::BOUND_W-1:0]     lim;
    logic [ppfa_pkg::BOUND_W-1:0]     start_b;
    logic [ppfa_pkg::BOUND_W-1:0]     idx_b;
    logic [ppfa_pkg::BOUND_W-1:0]     cnt_b;
    logic [ppfa_pkg::BOUND_W-1:0]     end_b;
    logic [ppfa_pkg::BOUND_W-1:0]     end_clip;
    logic                             clipped;
    logic [ppfa_pkg::COUNT_W-1:0]     burst;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_start <= ppfa_pkg::RESET_SEARCH_START;
            r_page_limit   <= ppfa_pkg::RESET_PAGE_LIMIT;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ppfa_pkg::CFG_SEARCH_START) begin
                r_search_start <= i_cfg_data[11:0];
            end else begin
                r_page_limit <= i_cfg_data;
            end
        end
    end

    // Effective limit and range arithmetic; an empty range is never clipped
    always_comb begin
        lim = ppfa_pkg::BOUND_W'(r_page_limit);
        if (lim > ppfa_pkg::BOUND_W'(NUM_PAGES)) begin
            lim = ppfa_pkg::BOUND_W'(NUM_PAGES);
        end
        start_b  = ppfa_pkg::BOUND_W'(r_search_start);
        idx_b    = ppfa_pkg::BOUND_W'(i_page_index);
        cnt_b    = ppfa_pkg::BOUND_W'(i_page_count);
        end_b    = idx_b + cnt_b;
        clipped  = (i_page_count != '0) && (end_b > lim);
        end_clip = clipped ? lim : end_b;
        burst    = (i_page_count > ppfa_pkg::COUNT_W'(MAX_BURST))
                 ? ppfa_pkg::COUNT_W'(MAX_BURST) : i_page_count;
    end

    // Classify the command word
    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = ppfa_pkg::OP_NOP;
        o_cmd.status   = ppfa_pkg::ST_OK;
        unique case (i_command)
            ppfa_pkg::CMD_ALLOC: begin
                if (i_page_count == '0) begin
                    o_cmd.status = ppfa_pkg::ST_OK;
                end else if (start_b >= lim) begin
                    o_cmd.status = ppfa_pkg::ST_OOM;
                end else begin
                    o_cmd.op    = ppfa_pkg::OP_ALLOC;
                    o_cmd.lo    = start_b;
                    o_cmd.hi    = lim;
                    o_cmd.count = burst;
                end
            end
            ppfa_pkg::CMD_FREE: begin
                if (idx_b >= lim) begin
                    o_cmd.status = ppfa_pkg::ST_RANGE;
                end else begin
                    o_cmd.op       = ppfa_pkg::OP_MARK;
                    o_cmd.mark_set = 1'b0;
                    o_cmd.lo       = idx_b;
                    o_cmd.hi       = idx_b + ppfa_pkg::BOUND_W'(1);
                end
            end
            ppfa_pkg::CMD_RESERVE: begin
                o_cmd.status = clipped ? ppfa_pkg::ST_RANGE : ppfa_pkg::ST_OK;
                if (idx_b < end_clip) begin
                    o_cmd.op       = ppfa_pkg::OP_MARK;
                    o_cmd.mark_set = 1'b1;
                    o_cmd.lo       = idx_b;
                    o_cmd.hi       = end_clip;
                end
            end
            default: begin
                o_cmd.status = ppfa_pkg::ST_OK;
            end
        endcase
    end

endmodule

>>> rtl/core/ppfa_queue.sv
// ----------------------------------------------------------------------------
// ppfa_queue
// Two-entry operation queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ppfa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppfa_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ppfa_pkg::t_cmd  o_cmd
);

    ppfa_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // Store pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/ppfa_back.sv
// ----------------------------------------------------------------------------
// ppfa_back
// Executes queued operations against the in-use bitmap memory: clearing
// pass after reset, first-fit allocation scan row by row, and masked
// read-modify-write for free and reserve. Drives the registered result word.
// ----------------------------------------------------------------------------
module ppfa_back #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  ppfa_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [ppfa_pkg::FRAME_W-1:0]  o_frame_index,
    output logic                          o_frame_valid,
    output logic [ppfa_pkg::COUNT_W-1:0]  o_found_count,
    output logic [1:0]                    o_status,
    output logic                          o_last
);

    localparam int NROWS = (NUM_PAGES + ppfa_pkg::WORD_W - 1) / ppfa_pkg::WORD_W;
    localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int WW    = ppfa_pkg::WORD_W;
    localparam int BW    = ppfa_pkg::BOUND_W;
    localparam int XW    = ppfa_pkg::WORD_IDX;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    // Bitmap memory
    logic [WW-1:0] r_map [NROWS];
    logic [WW-1:0] r_rd_data;
    logic          mem_we;
    logic          mem_re;
    logic [WW-1:0] mem_wdata;

    // Control state
    logic [2:0]                    r_state, n_state;
    logic [RW-1:0]                 r_row, n_row;
    ppfa_pkg::t_op                 r_op, n_op;
    logic                          r_set, n_set;
    logic [BW-1:0]                 r_lo, n_lo;
    logic [BW-1:0]                 r_hi, n_hi;
    logic [ppfa_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [ppfa_pkg::COUNT_W-1:0]  r_found, n_found;
    logic [1:0]                    r_status, n_status;
    logic [WW-1:0]                 r_word, n_word;
    logic                          r_pend, n_pend;
    logic [ppfa_pkg::FRAME_W-1:0]  r_pend_frame, n_pend_frame;

    // Result word
    logic                          r_out_valid, n_out_valid;
    logic [ppfa_pkg::FRAME_W-1:0]  r_out_frame, n_out_frame;
    logic                          r_out_fvalid, n_out_fvalid;
    logic [ppfa_pkg::COUNT_W-1:0]  r_out_found, n_out_found;
    logic [1:0]                    r_out_status, n_out_status;
    logic                          r_out_last, n_out_last;

    // Row mask terms
    logic [BW-1:0]  hi_page;
    logic [RW-1:0]  lo_row;
    logic [RW-1:0]  hi_row;
    logic [XW-1:0]  lo_bit;
    logic [XW-1:0]  hi_bit;
    logic [WW-1:0]  row_mask;
    logic [WW-1:0]  avail;
    logic [XW-1:0]  pick;
    logic [WW-1:0]  marked;

    assign o_strobe      = r_out_valid;
    assign o_frame_index = r_out_frame;
    assign o_frame_valid = r_out_fvalid;
    assign o_found_count = r_out_found;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

    // Write and read the bitmap, read data registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[r_row] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_map[r_row];
        end
    end

    // Build the mask of pages in [lo, hi) that fall in the current row
    always_comb begin
        hi_page  = r_hi - BW'(1);
        lo_row   = RW'(r_lo >> XW);
        hi_row   = RW'(hi_page >> XW);
        lo_bit   = r_lo[XW-1:0];
        hi_bit   = hi_page[XW-1:0];
        row_mask = '1;
        if (r_row == lo_row) begin
            row_mask = row_mask & ({WW{1'b1}} << lo_bit);
        end
        if (r_row == hi_row) begin
            row_mask = row_mask & ({WW{1'b1}} >> (XW'(WW - 1) - hi_bit));
        end
        avail = ~r_word & row_mask;
    end

    // Find the lowest free page of the row
    always_comb begin
        pick = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (avail[i]) begin
                pick = XW'(i);
            end
        end
        marked = r_word | (WW'(1) << pick);
    end

    // Sequence operations
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_op         = r_op;
        n_set        = r_set;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_count      = r_count;
        n_found      = r_found;
        n_status     = r_status;
        n_word       = r_word;
        n_pend       = r_pend;
        n_pend_frame = r_pend_frame;
        n_out_valid  = 1'b0;
        n_out_frame  = r_out_frame;
        n_out_fvalid = r_out_fvalid;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = '0;
        o_pop        = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_row == RW'(NROWS - 1)) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_op     = i_cmd.op;
                    n_set    = i_cmd.mark_set;
                    n_lo     = i_cmd.lo;
                    n_hi     = i_cmd.hi;
                    n_count  = i_cmd.count;
                    n_status = i_cmd.status;
                    n_found  = '0;
                    n_pend   = 1'b0;
                    n_row    = RW'(i_cmd.lo >> XW);
                    if (i_cmd.op == ppfa_pkg::OP_NOP) begin
                        // Immediate single result
                        n_out_valid  = 1'b1;
                        n_out_frame  = '0;
                        n_out_fvalid = 1'b0;
                        n_out_found  = '0;
                        n_out_status = i_cmd.status;
                        n_out_last   = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_op == ppfa_pkg::OP_ALLOC) begin
                    n_word  = r_rd_data;
                    n_state = S_SCAN;
                end else begin
                    // Set or clear the masked bits and write back
                    mem_we    = 1'b1;
                    mem_wdata = r_set ? (r_rd_data | row_mask) : (r_rd_data & ~row_mask);
                    if (r_row == hi_row) begin
                        n_out_valid  = 1'b1;
                        n_out_frame  = '0;
                        n_out_fvalid = 1'b0;
                        n_out_found  = '0;
                        n_out_status = r_status;
                        n_out_last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_row   = r_row + RW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_SCAN: begin
                if (avail != '0) begin
                    // Take one page, release the previous one as a result
                    n_word       = marked;
                    n_found      = r_found + ppfa_pkg::COUNT_W'(1);
                    n_pend       = 1'b1;
                    n_pend_frame = ppfa_pkg::FRAME_W'({r_row, pick});
                    if (r_pend) begin
                        n_out_valid  = 1'b1;
                        n_out_frame  = r_pend_frame;
                        n_out_fvalid = 1'b1;
                        n_out_found  = r_found;
                        n_out_status = ppfa_pkg::ST_OK;
                        n_out_last   = 1'b0;
                    end
                    if (n_found == r_count) begin
                        mem_we    = 1'b1;
                        mem_wdata = marked;
                        n_status  = ppfa_pkg::ST_OK;
                        n_state   = S_FIN;
                    end
                end else begin
                    // Row exhausted: write it back and move on
                    mem_we    = 1'b1;
                    mem_wdata = r_word;
                    if (r_row == hi_row) begin
                        n_status = ppfa_pkg::ST_OOM;
                        n_state  = S_FIN;
                    end else begin
                        n_row   = r_row + RW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_FIN: begin
                n_out_valid = 1'b1;
                n_out_last  = 1'b1;
                if (r_pend) begin
                    n_out_frame  = r_pend_frame;
                    n_out_fvalid = 1'b1;
                    n_out_found  = r_found;
                    n_out_status = r_status;
                end else begin
                    n_out_frame  = '0;
                    n_out_fvalid = 1'b0;
                    n_out_found  = '0;
                    n_out_status = ppfa_pkg::ST_OOM;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_op        <= ppfa_pkg::OP_NOP;
            r_found     <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_op        <= n_op;
            r_found     <= n_found;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_set        <= n_set;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_status     <= n_status;
        r_word       <= n_word;
        r_pend_frame <= n_pend_frame;
        r_out_frame  <= n_out_frame;
        r_out_fvalid <= n_out_fvalid;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // No result while the clearing pass runs
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !r_out_valid)
        else $error("result issued during bitmap clearing pass");

    // The scan never runs past the requested count
    a_found_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_found < r_count))
        else $error("allocation scan past requested count");

    // A delivered page always carries a nonzero running count
    a_page_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fvalid) |-> (r_out_found != '0))
        else $error("allocated page reported with zero count");

    // Popping either starts work or answers at once
    a_pop_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> ((r_state != S_IDLE) || r_out_valid))
        else $error("popped operation neither started nor answered");

endmodule

>>> rtl/core/physical_page_frame_allocator_top.sv
// Immediate answers touch no bitmap row; free and reserve read and write back each row
// they touch; allocate reads, scans and writes back each row in turn until it has found
// its pages or reached the limit.
// One command word runs at a time; a two-entry queue takes up to two more, then busy
// holds start off. Results cannot be stalled. Synchronous reset empties the queue and
// a clearing pass wipes every bitmap row before the first word runs.
// ----------------------------------------------------------------------------
// physical_page_frame_allocator_top
// Bitmap page frame allocator: first-fit multi-page allocation, single page
// free and range reserve over a per-page in-use bitmap.
// ----------------------------------------------------------------------------
module physical_page_frame_allocator_top #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [ppfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_command,
    input  logic [11:0]                      i_page_index,
    input  logic [ppfa_pkg::COUNT_W-1:0]     i_page_count,
    output logic                             o_result_strobe,
    output logic [ppfa_pkg::FRAME_W-1:0]     o_frame_index,
    output logic                             o_frame_valid,
    output logic [ppfa_pkg::COUNT_W-1:0]     o_found_count,
    output logic [1:0]                       o_status,
    output logic                             o_last
);

    ppfa_pkg::t_cmd front_cmd;
    ppfa_pkg::t_cmd queue_cmd;
    logic           queue_full;
    logic           queue_valid;
    logic           queue_pop;
    logic           push;

    assign busy = queue_full;
    assign push = start && !queue_full;

    // Classify incoming words
    ppfa_front #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_page_index (i_page_index),
        .i_page_count (i_page_count),
        .o_cmd        (front_cmd)
    );

    // Decouple front and back
    ppfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // Execute against the bitmap
    ppfa_back #(
        .NUM_PAGES (NUM_PAGES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (queue_valid),
        .i_cmd         (queue_cmd),
        .o_pop         (queue_pop),
        .o_strobe      (o_result_strobe),
        .o_frame_index (o_frame_index),
        .o_frame_valid (o_frame_valid),
        .o_found_count (o_found_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

>>> sim/ppfa_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppfa_frame_checker
// Watches the command, configuration and result channels of the page frame
// allocator, keeps its own in-use bitmap and register copies, predicts the
// result words of every accepted command and compares each result word,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ppfa_frame_checker #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_BURST = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [ppfa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             start,
    input  logic                             busy,
    input  logic [1:0]                       i_command,
    input  logic [11:0]                      i_page_index,
    input  logic [ppfa_pkg::COUNT_W-1:0]     i_page_count,
    input  logic                             o_result_strobe,
    input  logic [ppfa_pkg::FRAME_W-1:0]     o_frame_index,
    input  logic                             o_frame_valid,
    input  logic [ppfa_pkg::COUNT_W-1:0]     o_found_count,
    input  logic [1:0]                       o_status,
    input  logic                             o_last,
    output int                               o_fail_count,
    output int                               o_words_due,
    output int                               o_words_checked,
    output int                               o_oom_words
);

    typedef struct packed {
        logic [11:0] frame;
        logic        valid;
        logic [6:0]  found;
        logic [1:0]  status;
        logic        last;
    } t_frame_word;

    // Predicted result words, oldest first
    t_frame_word frame_words_due[$];

    // Own copy of the bitmap and the registers
    bit          page_used [NUM_PAGES];
    logic [11:0] scan_base;
    logic [12:0] page_cap;

    // Work out the result words of one command and update the bitmap
    task automatic predict_frame_words(input logic [1:0] cmd, input logic [11:0] idx,
                                       input logic [6:0] cnt);
        t_frame_word w;
        t_frame_word burst[$];
        int          lim;
        int          want;
        int          found;
        int          p;
        lim = (page_cap < NUM_PAGES) ? int'(page_cap) : NUM_PAGES;
        w = '0;
        w.last = 1'b1;
        case (cmd)
            ppfa_pkg::CMD_ALLOC: begin
                if (cnt == 0) begin
                    frame_words_due.push_back(w);
                end else begin
                    want = (cnt > MAX_BURST) ? MAX_BURST : int'(cnt);
                    found = 0;
                    // first fit upward from the scan base
                    for (p = int'(scan_base); p < lim && found < want; p++) begin
                        if (!page_used[p]) begin
                            page_used[p] = 1'b1;
                            found++;
                            w.frame = p[11:0];
                            w.valid = 1'b1;
                            w.found = found[6:0];
                            w.status = ppfa_pkg::ST_OK;
                            w.last = (found == want);
                            burst.push_back(w);
                        end
                    end
                    // shortfall: flag the final word, or answer with a lone empty one
                    if (found == 0) begin
                        w = '0;
                        w.status = ppfa_pkg::ST_OOM;
                        w.last = 1'b1;
                        burst.push_back(w);
                    end else if (found < want) begin
                        burst[found-1].status = ppfa_pkg::ST_OOM;
                        burst[found-1].last = 1'b1;
                    end
                    foreach (burst[k])
                        frame_words_due.push_back(burst[k]);
                end
            end
            ppfa_pkg::CMD_FREE: begin
                if (int'(idx) < lim)
                    page_used[idx] = 1'b0;
                else
                    w.status = ppfa_pkg::ST_RANGE;
                frame_words_due.push_back(w);
            end
            ppfa_pkg::CMD_RESERVE: begin
                // mark the range, clip at the limit
                for (p = int'(idx); p < int'(idx) + int'(cnt); p++) begin
                    if (p < lim)
                        page_used[p] = 1'b1;
                    else
                        w.status = ppfa_pkg::ST_RANGE;
                end
                frame_words_due.push_back(w);
            end
            default: begin
                frame_words_due.push_back(w);
            end
        endcase
    endtask

    // Compare one result word with the oldest prediction
    task automatic check_frame_word();
        t_frame_word got;
        t_frame_word exp_word;
        got = {o_frame_index, o_frame_valid, o_found_count, o_status, o_last};
        o_words_checked++;
        if (got.status == ppfa_pkg::ST_OOM)
            o_oom_words++;
        if (frame_words_due.size() == 0) begin
            if (o_fail_count < 10)
                $display("%0t: result word with none expected: frame %0d valid %0d found %0d status %0d last %0d",
                         $realtime, got.frame, got.valid, got.found, got.status, got.last);
            o_fail_count++;
        end else begin
            exp_word = frame_words_due.pop_front();
            if (got !== exp_word) begin
                if (o_fail_count < 10) begin
                    $display("%0t: result word mismatch", $realtime);
                    $display("  expected frame %0d valid %0d found %0d status %0d last %0d",
                             exp_word.frame, exp_word.valid, exp_word.found, exp_word.status,
                             exp_word.last);
                    $display("  actual   frame %0d valid %0d found %0d status %0d last %0d",
                             got.frame, got.valid, got.found, got.status, got.last);
                end
                o_fail_count++;
            end
        end
    endtask

    // Track reset, register writes, accepted commands and result words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (page_used[n])
                page_used[n] = 1'b0;
            scan_base = ppfa_pkg::RESET_SEARCH_START;
            page_cap = ppfa_pkg::RESET_PAGE_LIMIT;
            frame_words_due.delete();
        end else begin
            if (o_result_strobe === 1'b1)
                check_frame_word();
            if (i_cfg_we) begin
                if (i_cfg_idx == ppfa_pkg::CFG_SEARCH_START)
                    scan_base = i_cfg_data[11:0];
                else
                    page_cap = i_cfg_data[12:0];
            end
            if (start && busy === 1'b0)
                predict_frame_words(i_command, i_page_index, i_page_count);
        end
        o_words_due = frame_words_due.size();
    end

endmodule

>>> sim/physical_page_frame_allocator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// physical_page_frame_allocator_top_test
// Drives the page frame allocator with a directed set of allocate, free,
// reserve and unknown commands, then random phases under several register
// settings, with random gaps between words. The checker beside the block
// predicts and compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module physical_page_frame_allocator_top_test;

    localparam int NUM_PAGES = 4096;
    localparam int MAX_BURST = 64;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 36;

    // Command code with no defined operation
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic                            i_cfg_idx = 1'b0;
    logic [ppfa_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [1:0]                      i_command = 2'd0;
    logic [11:0]                     i_page_index = '0;
    logic [ppfa_pkg::COUNT_W-1:0]    i_page_count = '0;
    logic                            o_result_strobe;
    logic [ppfa_pkg::FRAME_W-1:0]    o_frame_index;
    logic                            o_frame_valid;
    logic [ppfa_pkg::COUNT_W-1:0]    o_found_count;
    logic [1:0]                      o_status;
    logic                            o_last;

    int fail_count;
    int words_due;
    int words_checked;
    int oom_words;

    int          words_sent [4];
    int          settings_used;
    int          calm_run;
    logic [11:0] cur_base;
    logic [12:0] cur_cap;

    physical_page_frame_allocator_top #(
        .NUM_PAGES(NUM_PAGES),
        .MAX_BURST(MAX_BURST)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_page_index(i_page_index),
        .i_page_count(i_page_count),
        .o_result_strobe(o_result_strobe),
        .o_frame_index(o_frame_index),
        .o_frame_valid(o_frame_valid),
        .o_found_count(o_found_count),
        .o_status(o_status),
        .o_last(o_last)
    );

    ppfa_frame_checker #(
        .NUM_PAGES(NUM_PAGES),
        .MAX_BURST(MAX_BURST)
    ) checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_page_index(i_page_index),
        .i_page_count(i_page_count),
        .o_result_strobe(o_result_strobe),
        .o_frame_index(o_frame_index),
        .o_frame_valid(o_frame_valid),
        .o_found_count(o_found_count),
        .o_status(o_status),
        .o_last(o_last),
        .o_fail_count(fail_count),
        .o_words_due(words_due),
        .o_words_checked(words_checked),
        .o_oom_words(oom_words)
    );

    always #1 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Send one command word after a random gap; start stays high after acceptance
    task automatic send_word(input logic [1:0] cmd, input logic [11:0] idx,
                             input logic [6:0] cnt);
        int gap;
        if (calm_run > 0) begin
            gap = 0;
            calm_run--;
        end else begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0)
                calm_run = $urandom_range(5, 15);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_page_index <= idx;
        i_page_count <= cnt;
        do @(posedge i_clk); while (busy !== 1'b0);
        words_sent[cmd]++;
    endtask

    // Hold off until every expected word has come and the block is idle
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (words_due != 0);
        repeat (16) @(posedge i_clk);
        do @(negedge i_clk); while (busy !== 1'b0);
    endtask

    // Write both registers while idle
    task automatic set_config(input logic [11:0] base, input logic [12:0] cap);
        settle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ppfa_pkg::CFG_SEARCH_START;
        i_cfg_data <= {1'b0, base};
        @(posedge i_clk);
        i_cfg_idx <= ppfa_pkg::CFG_PAGE_LIMIT;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_base = base;
        cur_cap = cap;
        settings_used++;
    endtask

    // One random command word, shaped around the current settings
    task automatic random_word();
        int          pick;
        int          lim;
        int          idx;
        int          cnt;
        logic [1:0]  cmd;
        lim = (cur_cap < NUM_PAGES) ? int'(cur_cap) : NUM_PAGES;
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            cmd = ppfa_pkg::CMD_ALLOC;
            idx = $urandom_range(0, 4095);
            pick = $urandom_range(0, 99);
            if (pick < 70)      cnt = $urandom_range(1, 16);
            else if (pick < 90) cnt = $urandom_range(17, 64);
            else if (pick < 97) cnt = $urandom_range(65, 127);
            else                cnt = 0;
        end else if (pick < 74) begin
            cmd = ppfa_pkg::CMD_FREE;
            cnt = $urandom_range(0, 127);
            if ($urandom_range(0, 9) < 6)
                idx = int'(cur_base) + $urandom_range(0, 255);
            else
                idx = $urandom_range(0, 4095);
        end else if (pick < 95) begin
            cmd = ppfa_pkg::CMD_RESERVE;
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            pick = $urandom_range(0, 3);
            if (pick == 0)      idx = lim - $urandom_range(0, 32);
            else if (pick == 1) idx = int'(cur_base) + $urandom_range(0, 255);
            else                idx = $urandom_range(0, 4095);
        end else begin
            cmd = CMD_UNUSED;
            idx = $urandom_range(0, 4095);
            cnt = $urandom_range(0, 127);
        end
        if (idx < 0)    idx = 0;
        if (idx > 4095) idx = 4095;
        send_word(cmd, idx[11:0], cnt[6:0]);
    endtask

    initial begin
        logic [11:0] bases [PHASES];
        logic [12:0] caps [PHASES];
        calm_run = 0;
        settings_used = 1;
        cur_base = ppfa_pkg::RESET_SEARCH_START;
        cur_cap = ppfa_pkg::RESET_PAGE_LIMIT;
        foreach (words_sent[c])
            words_sent[c] = 0;

        bases[0] = 12'd0;    caps[0] = 13'd4096;
        bases[1] = 12'd100;  caps[1] = 13'd356;
        bases[2] = 12'd4000; caps[2] = 13'd8191;
        bases[3] = 12'($urandom_range(0, 4095));
        caps[3] = 13'($urandom_range(0, 8191));
        bases[4] = 12'($urandom_range(0, 2047));
        caps[4] = 13'd4096;
        bases[5] = 12'd200;  caps[5] = 13'd1200;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All commands at reset settings; zero, single, full and saturated bursts
        send_word(ppfa_pkg::CMD_ALLOC, 12'd0, 7'd0);
        send_word(ppfa_pkg::CMD_ALLOC, 12'hfff, 7'd1);
        send_word(ppfa_pkg::CMD_ALLOC, 12'd0, 7'd64);
        send_word(ppfa_pkg::CMD_ALLOC, 12'd0, 7'd127);
        send_word(ppfa_pkg::CMD_FREE, 12'd48, 7'd0);
        send_word(ppfa_pkg::CMD_FREE, 12'hfff, 7'd127);
        send_word(ppfa_pkg::CMD_FREE, 12'd0, 7'd5);
        send_word(ppfa_pkg::CMD_RESERVE, 12'd0, 7'd0);
        send_word(ppfa_pkg::CMD_RESERVE, 12'd4090, 7'd10);
        send_word(ppfa_pkg::CMD_RESERVE, 12'hfff, 7'd127);
        send_word(ppfa_pkg::CMD_RESERVE, 12'd100, 7'd64);
        send_word(CMD_UNUSED, 12'hfff, 7'd127);
        send_word(CMD_UNUSED, 12'd0, 7'd0);
        send_word(ppfa_pkg::CMD_ALLOC, 12'd0, 7'd5);

        // Only the top page is usable: partial shortfall, then none at all
        set_config(12'hfff, 13'd4096);
        send_word(ppfa_pkg::CMD_FREE, 12'hfff, 7'd0);
        send_word(ppfa_pkg::CMD_ALLOC, 12'd0, 7'd3);
        send_word(ppfa_pkg::CMD_ALLOC, 12'd0, 7'd2);

        // No pages present: every index is out of range
        set_config(12'd0, 13'd0);
        send_word(ppfa_pkg::CMD_FREE, 12'd5, 7'd0);
        send_word(ppfa_pkg::CMD_ALLOC, 12'd0, 7'd1);
        send_word(ppfa_pkg::CMD_RESERVE, 12'd0, 7'd3);

        // Random phases, each under its own settings
        for (int ph = 0; ph < PHASES; ph++) begin
            set_config(bases[ph], caps[ph]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 39) == 0)
                    settle();
                random_word();
            end
        end

        // Drain and let the block close out
        settle();
        repeat (300) @(posedge i_clk);

        $display("Sent %0d allocate, %0d free, %0d reserve, %0d unknown words over %0d settings",
                 words_sent[ppfa_pkg::CMD_ALLOC], words_sent[ppfa_pkg::CMD_FREE],
                 words_sent[ppfa_pkg::CMD_RESERVE], words_sent[CMD_UNUSED], settings_used);
        $display("Checked %0d result words, %0d out of memory, %0d mismatches",
                 words_checked, oom_words, fail_count);
        if (fail_count == 0 && words_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
